>>> sv/sfpd_pkg.sv
`timescale 1ns / 1ps

package sfpd_pkg;

	localparam int FRAME_BITS_DEF = 32;
	localparam int QUEUE_DEPTH    = 2;
	localparam int WORD_W         = 32;
	localparam int DUR_W          = 16;
	localparam int TEMP_W         = 12;
	localparam int ID_W           = 8;
	localparam int CH_W           = 2;
	localparam int REP_W          = 4;
	localparam int CFG_IDX_W      = 3;
	localparam int CFG_DATA_W     = 16;
	localparam int PHASE_W        = 3;
	localparam int BIDX_W         = 5;
	localparam int SUM_W          = 8;

	localparam logic [PHASE_W-1:0] PH_IDLE      = 3'd0;
	localparam logic [PHASE_W-1:0] PH_PRE_PULSE = 3'd1;
	localparam logic [PHASE_W-1:0] PH_PRE_GAP   = 3'd2;
	localparam logic [PHASE_W-1:0] PH_BIT_PULSE = 3'd3;
	localparam logic [PHASE_W-1:0] PH_BIT_GAP   = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_DEVICE_ID    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PULSE        = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PREAMBLE_GAP = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ONE_GAP      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_GAP     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT       = 3'd6;

	localparam logic [ID_W-1:0]  RST_DEVICE_ID    = 8'd0;
	localparam logic [CH_W-1:0]  RST_CHANNEL      = 2'd0;
	localparam logic [DUR_W-1:0] RST_PULSE        = 16'd500;
	localparam logic [DUR_W-1:0] RST_PREAMBLE_GAP = 16'd8000;
	localparam logic [DUR_W-1:0] RST_ONE_GAP      = 16'd4000;
	localparam logic [DUR_W-1:0] RST_ZERO_GAP     = 16'd2000;
	localparam logic [REP_W-1:0] RST_REPEAT       = 4'd6;

	typedef struct packed {
		logic [ID_W-1:0]  device_id;
		logic [CH_W-1:0]  channel;
		logic [DUR_W-1:0] pulse_ticks;
		logic [DUR_W-1:0] preamble_gap_ticks;
		logic [DUR_W-1:0] one_gap_ticks;
		logic [DUR_W-1:0] zero_gap_ticks;
		logic [REP_W-1:0] repeat_count;
	} cfg_t;

	typedef struct packed {
		logic              is_send;
		logic [WORD_W-1:0] frame;
	} item_t;

	typedef struct packed {
		logic line_level;
		logic busy_res;
		logic frame_done;
		logic send_rejected;
	} result_t;

	function automatic logic [DUR_W-1:0] dur_of(logic [DUR_W-1:0] v);
		dur_of = (v == '0) ? DUR_W'(1) : v;
	endfunction

endpackage

>>> sv/sfpd_if.sv
`timescale 1ns / 1ps

interface sfpd_in_if;
	logic                              valid;
	logic                              ready;
	logic                              action;
	logic signed [sfpd_pkg::TEMP_W-1:0] temp_tenths;
	logic                              battery_ok;
	logic                              beep;

	modport source (output valid, action, temp_tenths, battery_ok, beep, input ready);
	modport sink (input valid, action, temp_tenths, battery_ok, beep, output ready);
endinterface

interface sfpd_out_if;
	logic valid;
	logic ready;
	logic line_level;
	logic busy_res;
	logic frame_done;
	logic send_rejected;

	modport source (output valid, line_level, busy_res, frame_done, send_rejected,
		input ready);
	modport sink (input valid, line_level, busy_res, frame_done, send_rejected,
		output ready);
endinterface

interface sfpd_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [sfpd_pkg::CFG_IDX_W-1:0]  index;
	logic [sfpd_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> sv/sfpd_front.sv
`timescale 1ns / 1ps

module sfpd_front (
	input  logic                 clk,
	input  logic                 arst_n,
	sfpd_in_if.sink              item,
	input  sfpd_pkg::cfg_t       cfg,
	output logic                 push,
	output sfpd_pkg::item_t      push_item,
	input  logic                 full
);

	logic                              v_s1;
	sfpd_pkg::item_t                   item_s1;
	logic [23:0]                       word;
	logic [sfpd_pkg::WORD_W-1:0]       wide;
	logic [sfpd_pkg::SUM_W-1:0]        sum;
	sfpd_pkg::item_t                   built;

	// The checksum adds the low bytes of the word taken at every nibble offset, then subtracts one.
	always_comb begin
		word = {cfg.device_id, $unsigned(item.temp_tenths), cfg.channel,
			~item.battery_ok, item.beep};
		wide = {8'd0, word};
		sum  = '0;
		for (int k = 0; k < 7; k++) begin
			sum = sum + sfpd_pkg::SUM_W'(wide >> (4 * k));
		end
		sum = sum - sfpd_pkg::SUM_W'(1);
		built.is_send = item.action;
		built.frame   = {sum, word};
	end

	assign push       = v_s1 && !full;
	assign push_item  = item_s1;
	assign item.ready = !v_s1 || !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (item.ready) begin
			v_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			item_s1 <= built;
		end
	end

endmodule

>>> sv/sfpd_queue.sv
`timescale 1ns / 1ps

module sfpd_queue #(
	parameter int DEPTH = sfpd_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  sfpd_pkg::item_t push_item,
	output logic            full,
	input  logic            pop,
	output sfpd_pkg::item_t head,
	output logic            empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	sfpd_pkg::item_t   mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

>>> sv/sfpd_back.sv
`timescale 1ns / 1ps

module sfpd_back #(
	parameter int FRAME_BITS = sfpd_pkg::FRAME_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  sfpd_pkg::cfg_t  cfg,
	input  sfpd_pkg::item_t head,
	input  logic            empty,
	output logic            pop,
	sfpd_out_if.source      result
);

	localparam logic [sfpd_pkg::BIDX_W-1:0] LAST_BIT = sfpd_pkg::BIDX_W'(FRAME_BITS - 1);

	logic [sfpd_pkg::WORD_W-1:0]  frame_q,  frame_n;
	logic [sfpd_pkg::PHASE_W-1:0] phase_q,  phase_n;
	logic [sfpd_pkg::BIDX_W-1:0]  bidx_q,   bidx_n;
	logic [sfpd_pkg::DUR_W-1:0]   dur_q,    dur_n;
	logic [sfpd_pkg::REP_W-1:0]   rep_q,    rep_n;
	logic                         active_q, active_n;
	logic [sfpd_pkg::DUR_W-1:0]   dec;
	logic [sfpd_pkg::REP_W-1:0]   rep_dec;
	sfpd_pkg::result_t            res, res_q;
	logic                         out_v_q;

	assign pop = !empty && (!out_v_q || result.ready);

	always_comb begin
		frame_n  = frame_q;
		phase_n  = phase_q;
		bidx_n   = bidx_q;
		dur_n    = dur_q;
		rep_n    = rep_q;
		active_n = active_q;
		res      = '0;
		dec      = dur_q - sfpd_pkg::DUR_W'(1);
		rep_dec  = rep_q - sfpd_pkg::REP_W'(1);
		if (head.is_send) begin
			if (active_q) begin
				res.send_rejected = 1'b1;
			end else begin
				frame_n = head.frame;
				rep_n   = cfg.repeat_count;
				bidx_n  = '0;
				if (cfg.repeat_count != '0) begin
					active_n = 1'b1;
					phase_n  = sfpd_pkg::PH_PRE_PULSE;
					dur_n    = sfpd_pkg::dur_of(cfg.pulse_ticks);
				end else begin
					phase_n = sfpd_pkg::PH_IDLE;
					dur_n   = '0;
				end
			end
			res.busy_res = active_n;
		end else if (active_q) begin
			res.busy_res   = 1'b1;
			res.line_level = (phase_q == sfpd_pkg::PH_PRE_PULSE) ||
				(phase_q == sfpd_pkg::PH_BIT_PULSE);
			dur_n = dec;
			if (dec == '0) begin
				unique case (phase_q)
					sfpd_pkg::PH_PRE_PULSE: begin
						phase_n = sfpd_pkg::PH_PRE_GAP;
						dur_n   = sfpd_pkg::dur_of(cfg.preamble_gap_ticks);
					end
					sfpd_pkg::PH_PRE_GAP: begin
						phase_n = sfpd_pkg::PH_BIT_PULSE;
						bidx_n  = LAST_BIT;
						dur_n   = sfpd_pkg::dur_of(cfg.pulse_ticks);
					end
					sfpd_pkg::PH_BIT_PULSE: begin
						phase_n = sfpd_pkg::PH_BIT_GAP;
						dur_n   = frame_q[bidx_q] ? sfpd_pkg::dur_of(cfg.one_gap_ticks)
							: sfpd_pkg::dur_of(cfg.zero_gap_ticks);
					end
					default: begin
						if (bidx_q != '0) begin
							bidx_n  = bidx_q - sfpd_pkg::BIDX_W'(1);
							phase_n = sfpd_pkg::PH_BIT_PULSE;
							dur_n   = sfpd_pkg::dur_of(cfg.pulse_ticks);
						end else begin
							rep_n = rep_dec;
							if (rep_dec == '0) begin
								active_n       = 1'b0;
								phase_n        = sfpd_pkg::PH_IDLE;
								dur_n          = '0;
								res.frame_done = 1'b1;
							end else begin
								phase_n = sfpd_pkg::PH_PRE_PULSE;
								dur_n   = sfpd_pkg::dur_of(cfg.pulse_ticks);
							end
						end
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q  <= '0;
			phase_q  <= sfpd_pkg::PH_IDLE;
			bidx_q   <= '0;
			dur_q    <= '0;
			rep_q    <= '0;
			active_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (pop) begin
				frame_q  <= frame_n;
				phase_q  <= phase_n;
				bidx_q   <= bidx_n;
				dur_q    <= dur_n;
				rep_q    <= rep_n;
				active_q <= active_n;
				out_v_q  <= 1'b1;
			end else if (result.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= res;
		end
	end

	assign result.valid         = out_v_q;
	assign result.line_level    = res_q.line_level;
	assign result.busy_res      = res_q.busy_res;
	assign result.frame_done    = res_q.frame_done;
	assign result.send_rejected = res_q.send_rejected;

endmodule

>>> sv/sensor_frame_pulse_distance_transmitter.sv
`timescale 1ns / 1ps

// Pulse-distance transmitter for a temperature sensor frame.
// The item channel takes either a tick (action low) or a send request carrying a
// temperature, a battery flag and a beep flag. Every request yields exactly one
// result on the result channel: the line level for that tick, the busy flag, a
// done flag on the last tick of the last repetition and a flag for a rejected send.
// The cfg channel writes the seven timing and identity registers by index; it is
// always ready and is meant to be used while no request is in flight.
// A request is registered in the front stage, where the frame and its checksum are
// built, then passes a two-entry queue to the transmit engine, whose output
// register holds the result. One request is accepted and one result delivered per
// cycle when the receiver keeps ready high; the transmit engine's state update sets
// that rate. When the receiver stalls, the output register holds, the queue fills
// and the item channel drops ready; no request is lost.
// Reset clears the engine to idle with the line low and loads the register defaults.
module sensor_frame_pulse_distance_transmitter #(
	parameter int FRAME_BITS = sfpd_pkg::FRAME_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	sfpd_in_if.sink      item,
	sfpd_out_if.source   result,
	sfpd_cfg_if.sink     cfg
);

	sfpd_pkg::cfg_t  cfg_q;
	logic            push;
	sfpd_pkg::item_t push_item;
	logic            full;
	logic            pop;
	sfpd_pkg::item_t head;
	logic            empty;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.device_id          <= sfpd_pkg::RST_DEVICE_ID;
			cfg_q.channel            <= sfpd_pkg::RST_CHANNEL;
			cfg_q.pulse_ticks        <= sfpd_pkg::RST_PULSE;
			cfg_q.preamble_gap_ticks <= sfpd_pkg::RST_PREAMBLE_GAP;
			cfg_q.one_gap_ticks      <= sfpd_pkg::RST_ONE_GAP;
			cfg_q.zero_gap_ticks     <= sfpd_pkg::RST_ZERO_GAP;
			cfg_q.repeat_count       <= sfpd_pkg::RST_REPEAT;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				sfpd_pkg::REG_DEVICE_ID:    cfg_q.device_id <= cfg.data[sfpd_pkg::ID_W-1:0];
				sfpd_pkg::REG_CHANNEL:      cfg_q.channel <= cfg.data[sfpd_pkg::CH_W-1:0];
				sfpd_pkg::REG_PULSE:        cfg_q.pulse_ticks <= cfg.data;
				sfpd_pkg::REG_PREAMBLE_GAP: cfg_q.preamble_gap_ticks <= cfg.data;
				sfpd_pkg::REG_ONE_GAP:      cfg_q.one_gap_ticks <= cfg.data;
				sfpd_pkg::REG_ZERO_GAP:     cfg_q.zero_gap_ticks <= cfg.data;
				sfpd_pkg::REG_REPEAT:
					cfg_q.repeat_count <= cfg.data[sfpd_pkg::REP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	sfpd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cfg       (cfg_q),
		.push      (push),
		.push_item (push_item),
		.full      (full)
	);

	sfpd_queue #(
		.DEPTH (sfpd_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (full),
		.pop       (pop),
		.head      (head),
		.empty     (empty)
	);

	sfpd_back #(
		.FRAME_BITS (FRAME_BITS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.head   (head),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	a_done_not_rejected: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> !(result.frame_done && result.send_rejected))
		else $error("frame done and send rejected in one result");

	a_done_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.frame_done) |-> result.busy_res)
		else $error("frame done reported outside a transmission");

	a_level_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.line_level) |-> result.busy_res)
		else $error("line driven high while idle");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("transmit engine took a request from an empty queue");

endmodule

>>> tb/tb_sensor_frame_pulse_distance_transmitter.sv
`timescale 1ns / 1ps

module tb_sensor_frame_pulse_distance_transmitter;

	localparam int LINE_BITS = sfpd_pkg::FRAME_BITS_DEF;
	localparam logic [sfpd_pkg::CFG_IDX_W-1:0] REG_SPARE = 3'd7;
	localparam int STALL_LIMIT = 5000;
	localparam int HOLD_CYCLES = 300;
	localparam int LIVE_TARGET = 1600;

	class line_tracker;
		sfpd_pkg::cfg_t regs;
		logic [sfpd_pkg::WORD_W-1:0] frame_word;
		logic [sfpd_pkg::PHASE_W-1:0] phase;
		logic [sfpd_pkg::BIDX_W-1:0] bit_idx;
		logic [sfpd_pkg::DUR_W-1:0] ticks_left;
		logic [sfpd_pkg::REP_W-1:0] repeats_left;
		bit active;
		sfpd_pkg::result_t levels_due[$];
		int mismatches;

		function new();
			regs = '{device_id: sfpd_pkg::RST_DEVICE_ID, channel: sfpd_pkg::RST_CHANNEL,
				pulse_ticks: sfpd_pkg::RST_PULSE,
				preamble_gap_ticks: sfpd_pkg::RST_PREAMBLE_GAP,
				one_gap_ticks: sfpd_pkg::RST_ONE_GAP,
				zero_gap_ticks: sfpd_pkg::RST_ZERO_GAP,
				repeat_count: sfpd_pkg::RST_REPEAT};
			frame_word = '0;
			phase = sfpd_pkg::PH_IDLE;
			bit_idx = '0;
			ticks_left = '0;
			repeats_left = '0;
			active = 0;
			mismatches = 0;
		endfunction

		function void write_reg(logic [sfpd_pkg::CFG_IDX_W-1:0] idx,
				logic [sfpd_pkg::CFG_DATA_W-1:0] data);
			case (idx)
				sfpd_pkg::REG_DEVICE_ID: regs.device_id = data[sfpd_pkg::ID_W-1:0];
				sfpd_pkg::REG_CHANNEL: regs.channel = data[sfpd_pkg::CH_W-1:0];
				sfpd_pkg::REG_PULSE: regs.pulse_ticks = data;
				sfpd_pkg::REG_PREAMBLE_GAP: regs.preamble_gap_ticks = data;
				sfpd_pkg::REG_ONE_GAP: regs.one_gap_ticks = data;
				sfpd_pkg::REG_ZERO_GAP: regs.zero_gap_ticks = data;
				sfpd_pkg::REG_REPEAT: regs.repeat_count = data[sfpd_pkg::REP_W-1:0];
				default: ;
			endcase
		endfunction

		function logic [sfpd_pkg::DUR_W-1:0] span_of(logic [sfpd_pkg::DUR_W-1:0] v);
			return (v == '0) ? sfpd_pkg::DUR_W'(1) : v;
		endfunction

		// The checksum adds the low byte of the word at every nibble offset, then subtracts one.
		function logic [sfpd_pkg::WORD_W-1:0] pack_frame(logic [sfpd_pkg::TEMP_W-1:0] temp,
				bit batt_ok, bit beep_on);
			logic [23:0] w;
			logic [31:0] total;
			logic [sfpd_pkg::SUM_W-1:0] sum8;
			w = {regs.device_id, temp, regs.channel, ~batt_ok, beep_on};
			total = '0;
			for (int k = 0; k < 7; k++)
				total += (32'(w) >> (4 * k)) & 32'hFF;
			sum8 = sfpd_pkg::SUM_W'(total - 32'd1);
			return {sum8, w};
		endfunction

		function void take_request(bit send, logic [sfpd_pkg::TEMP_W-1:0] temp, bit batt_ok,
				bit beep_on);
			sfpd_pkg::result_t r;
			r = '0;
			if (send) begin
				if (active) begin
					r.send_rejected = 1'b1;
				end else begin
					frame_word = pack_frame(temp, batt_ok, beep_on);
					repeats_left = regs.repeat_count;
					bit_idx = '0;
					if (repeats_left != '0) begin
						active = 1;
						phase = sfpd_pkg::PH_PRE_PULSE;
						ticks_left = span_of(regs.pulse_ticks);
					end else begin
						phase = sfpd_pkg::PH_IDLE;
						ticks_left = '0;
					end
				end
				r.busy_res = active;
			end else if (active) begin
				r.busy_res = 1'b1;
				r.line_level = (phase == sfpd_pkg::PH_PRE_PULSE) ||
					(phase == sfpd_pkg::PH_BIT_PULSE);
				ticks_left = ticks_left - sfpd_pkg::DUR_W'(1);
				if (ticks_left == '0) begin
					case (phase)
						sfpd_pkg::PH_PRE_PULSE: begin
							phase = sfpd_pkg::PH_PRE_GAP;
							ticks_left = span_of(regs.preamble_gap_ticks);
						end
						sfpd_pkg::PH_PRE_GAP: begin
							phase = sfpd_pkg::PH_BIT_PULSE;
							bit_idx = sfpd_pkg::BIDX_W'(LINE_BITS - 1);
							ticks_left = span_of(regs.pulse_ticks);
						end
						sfpd_pkg::PH_BIT_PULSE: begin
							phase = sfpd_pkg::PH_BIT_GAP;
							ticks_left = frame_word[bit_idx] ? span_of(regs.one_gap_ticks)
								: span_of(regs.zero_gap_ticks);
						end
						default: begin
							if (bit_idx != '0) begin
								bit_idx = bit_idx - sfpd_pkg::BIDX_W'(1);
								phase = sfpd_pkg::PH_BIT_PULSE;
								ticks_left = span_of(regs.pulse_ticks);
							end else begin
								repeats_left = repeats_left - sfpd_pkg::REP_W'(1);
								if (repeats_left == '0) begin
									active = 0;
									phase = sfpd_pkg::PH_IDLE;
									ticks_left = '0;
									r.frame_done = 1'b1;
								end else begin
									phase = sfpd_pkg::PH_PRE_PULSE;
									ticks_left = span_of(regs.pulse_ticks);
								end
							end
						end
					endcase
				end
			end
			levels_due.push_back(r);
		endfunction

		function void match_result(sfpd_pkg::result_t got);
			sfpd_pkg::result_t want;
			if (levels_due.size() == 0) begin
				$display("%0t: result with none expected: %b", $time, got);
				mismatches++;
				return;
			end
			want = levels_due.pop_front();
			if (got.line_level !== want.line_level)
				$display("%0t: line_level expected %0b actual %0b", $time,
					want.line_level, got.line_level);
			if (got.busy_res !== want.busy_res)
				$display("%0t: busy_res expected %0b actual %0b", $time,
					want.busy_res, got.busy_res);
			if (got.frame_done !== want.frame_done)
				$display("%0t: frame_done expected %0b actual %0b", $time,
					want.frame_done, got.frame_done);
			if (got.send_rejected !== want.send_rejected)
				$display("%0t: send_rejected expected %0b actual %0b", $time,
					want.send_rejected, got.send_rejected);
			if (got !== want)
				mismatches++;
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit steady;
	bit hold_now;
	int live_items;
	line_tracker tracker;

	sfpd_in_if item_ch();
	sfpd_out_if res_ch();
	sfpd_cfg_if cfg_ch();

	sensor_frame_pulse_distance_transmitter dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.result(res_ch),
		.cfg(cfg_ch)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial tracker = new();

	task automatic offer_request(bit send, logic [sfpd_pkg::TEMP_W-1:0] temp, bit batt_ok,
			bit beep_on);
		while (!steady && $urandom_range(99) < 27) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.action <= send;
		item_ch.temp_tenths <= temp;
		item_ch.battery_ok <= batt_ok;
		item_ch.beep <= beep_on;
		do @(posedge clk); while (!item_ch.ready);
		if (send || tracker.active)
			live_items++;
		tracker.take_request(send, temp, batt_ok, beep_on);
	endtask

	task automatic offer_tick();
		offer_request(1'b0, sfpd_pkg::TEMP_W'($urandom), 1'($urandom), 1'($urandom));
	endtask

	task automatic offer_reading();
		offer_request(1'b1, sfpd_pkg::TEMP_W'($urandom), 1'($urandom), 1'($urandom));
	endtask

	task automatic drain();
		item_ch.valid <= 1'b0;
		while (tracker.levels_due.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic cfg_write(logic [sfpd_pkg::CFG_IDX_W-1:0] idx,
			logic [sfpd_pkg::CFG_DATA_W-1:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		tracker.write_reg(idx, data);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply(sfpd_pkg::cfg_t s);
		drain();
		cfg_write(sfpd_pkg::REG_DEVICE_ID, sfpd_pkg::CFG_DATA_W'(s.device_id));
		cfg_write(sfpd_pkg::REG_CHANNEL, sfpd_pkg::CFG_DATA_W'(s.channel));
		cfg_write(sfpd_pkg::REG_PULSE, s.pulse_ticks);
		cfg_write(sfpd_pkg::REG_PREAMBLE_GAP, s.preamble_gap_ticks);
		cfg_write(sfpd_pkg::REG_ONE_GAP, s.one_gap_ticks);
		cfg_write(sfpd_pkg::REG_ZERO_GAP, s.zero_gap_ticks);
		cfg_write(sfpd_pkg::REG_REPEAT, sfpd_pkg::CFG_DATA_W'(s.repeat_count));
	endtask

	function automatic logic [sfpd_pkg::DUR_W-1:0] pick_span();
		int r;
		r = $urandom_range(99);
		if (r < 20)
			return '0;
		if (r < 85)
			return sfpd_pkg::DUR_W'($urandom_range(1, 3));
		return sfpd_pkg::DUR_W'($urandom_range(4, 8));
	endfunction

	function automatic sfpd_pkg::cfg_t random_settings();
		sfpd_pkg::cfg_t s;
		s.device_id = sfpd_pkg::ID_W'($urandom);
		s.channel = sfpd_pkg::CH_W'($urandom);
		s.pulse_ticks = pick_span();
		s.preamble_gap_ticks = pick_span();
		s.one_gap_ticks = pick_span();
		s.zero_gap_ticks = pick_span();
		s.repeat_count = ($urandom_range(99) < 8) ? '0 :
			sfpd_pkg::REP_W'($urandom_range(1, 2));
		return s;
	endfunction

	// Mostly complete frames; a few ticks while idle and a few requests that collide with
	// a running frame.
	task automatic run_frames(int frames);
		for (int f = 0; f < frames; f++) begin
			if ($urandom_range(99) < 15)
				repeat ($urandom_range(1, 2)) offer_tick();
			offer_reading();
			while (tracker.active) begin
				if ($urandom_range(99) < 5)
					offer_reading();
				else
					offer_tick();
			end
		end
	endtask

	initial begin
		int hold_left;
		sfpd_pkg::result_t got;
		hold_left = 0;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (res_ch.valid && res_ch.ready) begin
				got.line_level = res_ch.line_level;
				got.busy_res = res_ch.busy_res;
				got.frame_done = res_ch.frame_done;
				got.send_rejected = res_ch.send_rejected;
				tracker.match_result(got);
			end
			if (!arst_n) begin
				res_ch.ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else if (hold_now) begin
				hold_now = 0;
				hold_left = HOLD_CYCLES;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= steady || ($urandom_range(99) >= 27);
			end
		end
	end

	initial begin
		int stalled;
		stalled = 0;
		forever begin
			@(posedge clk);
			if (!arst_n || (item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready)
					|| (cfg_ch.valid && cfg_ch.ready))
				stalled = 0;
			else
				stalled++;
			if (stalled >= STALL_LIMIT) begin
				$display("%0t: no request moved for %0d cycles", $time, stalled);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin
		sfpd_pkg::cfg_t s;
		int round;
		int frames;
		item_ch.valid <= 1'b0;
		item_ch.action <= 1'b0;
		item_ch.temp_tenths <= '0;
		item_ch.battery_ok <= 1'b0;
		item_ch.beep <= 1'b0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= '0;
		cfg_ch.data <= '0;
		arst_n <= 1'b0;
		steady = 0;
		hold_now = 0;
		live_items = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		offer_request(1'b0, 12'h000, 1'b1, 1'b0);
		offer_request(1'b0, 12'hFFF, 1'b0, 1'b1);
		drain();
		cfg_write(sfpd_pkg::REG_REPEAT, '0);
		offer_request(1'b1, 12'h800, 1'b0, 1'b1);
		offer_request(1'b1, 12'h7FF, 1'b1, 1'b0);
		drain();
		cfg_write(REG_SPARE, 16'hFFFF);
		s = '{device_id: 8'hFF, channel: 2'd3, pulse_ticks: 16'hFFFF,
			preamble_gap_ticks: 16'hFFFF, one_gap_ticks: 16'hFFFF, zero_gap_ticks: 16'hFFFF,
			repeat_count: 4'd0};
		apply(s);
		offer_request(1'b1, 12'h000, 1'b1, 1'b1);
		s.pulse_ticks = '0;
		s.preamble_gap_ticks = '0;
		s.one_gap_ticks = '0;
		s.zero_gap_ticks = '0;
		s.repeat_count = 4'd1;
		apply(s);
		offer_request(1'b1, 12'hFFF, 1'b0, 1'b1);
		repeat (5) offer_tick();
		offer_reading();
		while (tracker.active) offer_tick();
		offer_tick();

		round = 0;
		while (live_items < LIVE_TARGET) begin
			s = random_settings();
			frames = $urandom_range(1, 3);
			steady = (round == 2);
			if (round == 1 && s.repeat_count == '0)
				s.repeat_count = 4'd1;
			if (round == 0) begin
				s.pulse_ticks = '0;
				s.preamble_gap_ticks = 16'd1;
				s.one_gap_ticks = '0;
				s.zero_gap_ticks = 16'd1;
				s.repeat_count = 4'd15;
				frames = 1;
			end
			apply(s);
			// The receiver holds off while requests keep coming, so the block backs up.
			if (round == 1)
				hold_now = 1;
			run_frames(frames);
			round++;
		end

		steady = 1;
		s = random_settings();
		s.pulse_ticks = '0;
		s.preamble_gap_ticks = 16'd100;
		s.one_gap_ticks = '0;
		s.zero_gap_ticks = '0;
		s.repeat_count = 4'd1;
		apply(s);
		run_frames(1);
		steady = 0;
		drain();

		if (tracker.mismatches == 0 && tracker.levels_due.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
